@@ rtl/sdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Site directory message parser package
// Result kinds, field sizes and the shared kind type for the directory parser.
// ----------------------------------------------------------------------------
package sdm_pkg;

  typedef logic [3:0] kind_t;

  // Result kinds carried on the output channel.
  localparam kind_t KIND_TYPE      = 4'd0;
  localparam kind_t KIND_SITE_NAME = 4'd1;
  localparam kind_t KIND_DESC      = 4'd2;
  localparam kind_t KIND_COUNT     = 4'd3;
  localparam kind_t KIND_ST_NUM    = 4'd4;
  localparam kind_t KIND_ST_NAME   = 4'd5;
  localparam kind_t KIND_ADDR      = 4'd6;
  localparam kind_t KIND_DPORT     = 4'd7;
  localparam kind_t KIND_IPORT     = 4'd8;
  localparam kind_t KIND_RATE      = 4'd9;

  // Byte counts of the multi-byte station fields.
  localparam logic [2:0] ADDR_BYTES = 3'd4;
  localparam logic [2:0] PORT_BYTES = 3'd2;
  localparam logic [2:0] RATE_BYTES = 3'd4;

endpackage

@@ rtl/site_directory_message_parser.sv @@
// ----------------------------------------------------------------------------
// Site directory message parser
// Parses a length-prefixed directory message one byte per beat and emits
// each completed field with its kind and station index.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid_i/in_ready_o| data_byte_i, start_req_i
//  output  | out_valid_o/out_ready_i | kind_o, value_o, station_index_o, last_o
//
// One byte is taken every cycle; its result, if any, appears on the output
// register in the next cycle. The parse state and the result register are
// updated together, so the only limit is the single output register: a byte
// is taken whenever that register is empty or is being drained.
// Reset returns the parser to idle; bytes before a start mark are dropped.
// ----------------------------------------------------------------------------
module site_directory_message_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                start_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdm_pkg::kind_t      kind_o,
  output logic [31:0]         value_o,
  output logic [7:0]          station_index_o,
  output logic                last_o
);
  import sdm_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_SNAME_LEN = 4'd1;
  localparam logic [3:0] PH_SNAME     = 4'd2;
  localparam logic [3:0] PH_DESC_LEN  = 4'd3;
  localparam logic [3:0] PH_DESC      = 4'd4;
  localparam logic [3:0] PH_COUNT     = 4'd5;
  localparam logic [3:0] PH_ST_NUM    = 4'd6;
  localparam logic [3:0] PH_ST_LEN    = 4'd7;
  localparam logic [3:0] PH_ST_NAME   = 4'd8;
  localparam logic [3:0] PH_ADDR      = 4'd9;
  localparam logic [3:0] PH_DPORT     = 4'd10;
  localparam logic [3:0] PH_IPORT     = 4'd11;
  localparam logic [3:0] PH_RATE      = 4'd12;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  st_left_q, st_left_d;
  logic [7:0]  st_cur_q, st_cur_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  fbc_q, fbc_d;

  logic        out_valid_q;
  kind_t       kind_q;
  logic [31:0] value_q;
  logic [7:0]  st_idx_q;
  logic        last_q;

  logic        in_fire;
  logic        res_valid;
  kind_t       res_kind;
  logic [31:0] res_value;
  logic [7:0]  res_idx;
  logic        res_last;

  logic [31:0] acc_shift;
  logic [2:0]  fbc_inc;
  logic [7:0]  remain_dec;
  logic [2:0]  need;
  logic        field_done;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign acc_shift  = {acc_q[23:0], data_byte_i};
  assign fbc_inc    = {1'b0, fbc_q} + 3'd1;
  assign remain_dec = remain_q - 8'd1;

  always_comb begin
    unique case (phase_q)
      PH_ADDR:             need = ADDR_BYTES;
      PH_DPORT, PH_IPORT:  need = PORT_BYTES;
      default:             need = RATE_BYTES;
    endcase
  end
  assign field_done = fbc_inc >= need;

  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    st_left_d = st_left_q;
    st_cur_d  = st_cur_q;
    acc_d     = acc_q;
    fbc_d     = fbc_q;
    res_valid = 1'b0;
    res_kind  = KIND_TYPE;
    res_value = {24'd0, data_byte_i};
    res_idx   = st_cur_q;
    res_last  = 1'b0;

    if (start_req_i) begin
      st_left_d = 8'd0;
      st_cur_d  = 8'd0;
      acc_d     = 32'd0;
      fbc_d     = 2'd0;
      remain_d  = 8'd0;
      phase_d   = PH_SNAME_LEN;
      res_valid = 1'b1;
      res_kind  = KIND_TYPE;
      res_idx   = 8'd0;
    end else begin
      unique case (phase_q)
        PH_SNAME_LEN: begin
          remain_d = data_byte_i;
          phase_d  = (data_byte_i == 8'd0) ? PH_DESC_LEN : PH_SNAME;
        end
        PH_SNAME: begin
          remain_d  = remain_dec;
          if (remain_dec == 8'd0) phase_d = PH_DESC_LEN;
          res_valid = 1'b1;
          res_kind  = KIND_SITE_NAME;
          res_idx   = 8'd0;
        end
        PH_DESC_LEN: begin
          remain_d = data_byte_i;
          phase_d  = (data_byte_i == 8'd0) ? PH_COUNT : PH_DESC;
        end
        PH_DESC: begin
          remain_d  = remain_dec;
          if (remain_dec == 8'd0) phase_d = PH_COUNT;
          res_valid = 1'b1;
          res_kind  = KIND_DESC;
          res_idx   = 8'd0;
        end
        PH_COUNT: begin
          st_left_d = data_byte_i;
          st_cur_d  = 8'd0;
          phase_d   = (data_byte_i == 8'd0) ? PH_IDLE : PH_ST_NUM;
          res_valid = 1'b1;
          res_kind  = KIND_COUNT;
          res_idx   = 8'd0;
          res_last  = (data_byte_i == 8'd0);
        end
        PH_ST_NUM: begin
          phase_d   = PH_ST_LEN;
          res_valid = 1'b1;
          res_kind  = KIND_ST_NUM;
        end
        PH_ST_LEN: begin
          remain_d = data_byte_i;
          phase_d  = (data_byte_i == 8'd0) ? PH_ADDR : PH_ST_NAME;
          acc_d    = 32'd0;
          fbc_d    = 2'd0;
        end
        PH_ST_NAME: begin
          remain_d  = remain_dec;
          if (remain_dec == 8'd0) phase_d = PH_ADDR;
          res_valid = 1'b1;
          res_kind  = KIND_ST_NAME;
        end
        PH_ADDR, PH_DPORT, PH_IPORT, PH_RATE: begin
          if (!field_done) begin
            acc_d = acc_shift;
            fbc_d = fbc_inc[1:0];
          end else begin
            acc_d     = 32'd0;
            fbc_d     = 2'd0;
            res_valid = 1'b1;
            res_value = acc_shift;
            unique case (phase_q)
              PH_ADDR: begin
                res_kind = KIND_ADDR;
                phase_d  = PH_DPORT;
              end
              PH_DPORT: begin
                res_kind  = KIND_DPORT;
                res_value = {16'd0, acc_shift[15:0]};
                phase_d   = PH_IPORT;
              end
              PH_IPORT: begin
                res_kind  = KIND_IPORT;
                res_value = {16'd0, acc_shift[15:0]};
                phase_d   = PH_RATE;
              end
              default: begin
                // Bit rate closes the station; the last station ends the message.
                res_kind  = KIND_RATE;
                st_left_d = st_left_q - 8'd1;
                res_last  = (st_left_q == 8'd1);
                if (st_left_q == 8'd1) begin
                  phase_d = PH_IDLE;
                end else begin
                  st_cur_d = st_cur_q + 8'd1;
                  phase_d  = PH_ST_NUM;
                end
              end
            endcase
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remain_q    <= 8'd0;
      st_left_q   <= 8'd0;
      st_cur_q    <= 8'd0;
      acc_q       <= 32'd0;
      fbc_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        remain_q    <= remain_d;
        st_left_q   <= st_left_d;
        st_cur_q    <= st_cur_d;
        acc_q       <= acc_d;
        fbc_q       <= fbc_d;
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q   <= res_kind;
      value_q  <= res_value;
      st_idx_q <= res_idx;
      last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign value_o         = value_q;
  assign station_index_o = st_idx_q;
  assign last_o          = last_q;

`ifndef NO_ASSERTIONS
  // The message can only end on a zero count or on a bit rate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      ((kind_o == KIND_COUNT && value_o == 32'd0) || kind_o == KIND_RATE))
    else $error("last beat on a field that cannot end the message");

  // Site fields always belong to station zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_TYPE || kind_o == KIND_SITE_NAME ||
                     kind_o == KIND_DESC || kind_o == KIND_COUNT)) |->
      (station_index_o == 8'd0))
    else $error("site field carries a non-zero station index");

  // An idle parser gives no result for a byte without a start mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_IDLE && !start_req_i) |=> !out_valid_o)
    else $error("result produced for a byte outside a message");

  // The field byte count is clear outside the multi-byte station fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(phase_q == PH_ADDR || phase_q == PH_DPORT || phase_q == PH_IPORT ||
      phase_q == PH_RATE) |-> (fbc_q == 2'd0))
    else $error("field byte count left over outside a multi-byte field");
`endif

endmodule
